// ===== rtl/triangle_overlap_sat_test_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the triangle overlap test RTL.
// Each macro checks on the rising edge of clk, and is off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_OVERLAP_SAT_TEST_ASSERT_SVH
`define TRIANGLE_OVERLAP_SAT_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRI_SAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tri_sat assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TRI_SAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tri_sat assertion failed");

`endif

// ===== rtl/tri_sat_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap test package
// Widths, types and lane control shared by the separating axis test blocks.
// ----------------------------------------------------------------------------
package tri_sat_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NRM_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = COORD_WIDTH + NRM_WIDTH;
    localparam int PROJ_WIDTH  = PROD_WIDTH + 1;

    localparam int VTX_PER_TRI = 3;
    localparam int NUM_VTX     = 2 * VTX_PER_TRI;
    localparam int NUM_LANES   = NUM_VTX;
    localparam int NUM_STAGES  = 7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [NRM_WIDTH-1:0]   norm_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [PROJ_WIDTH-1:0]  proj_t;

    typedef struct packed {
        logic nrm;
        logic prod;
        logic proj;
        logic ext;
        logic gap;
    } lane_en_t;

endpackage

// ===== rtl/tri_sat_lane.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap axis lane
// Tests one edge normal as a separating axis over five pipeline stages.
// ----------------------------------------------------------------------------
module tri_sat_lane
    import tri_sat_pkg::*;
(
    input  logic     clk,
    input  lane_en_t en,
    input  coord_t   p_x,
    input  coord_t   p_y,
    input  coord_t   q_x,
    input  coord_t   q_y,
    input  coord_t   vx [NUM_VTX],
    input  coord_t   vy [NUM_VTX],
    output logic     sep
);

    norm_t nx_reg;
    norm_t ny_reg;
    norm_t nx_next;
    norm_t ny_next;
    prod_t prod_x_reg [NUM_VTX];
    prod_t prod_y_reg [NUM_VTX];
    prod_t prod_x_next [NUM_VTX];
    prod_t prod_y_next [NUM_VTX];
    proj_t proj_reg [NUM_VTX];
    proj_t proj_next [NUM_VTX];
    proj_t min_reg [2];
    proj_t max_reg [2];
    proj_t min_next [2];
    proj_t max_next [2];
    logic  sep_reg;
    logic  sep_next;

    always_comb
    begin
        nx_next = norm_t'(q_y) - norm_t'(p_y);
        ny_next = norm_t'(p_x) - norm_t'(q_x);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_VTX; i++)
        begin
            prod_x_next[i] = prod_t'(vx[i]) * prod_t'(nx_reg);
            prod_y_next[i] = prod_t'(vy[i]) * prod_t'(ny_reg);
            proj_next[i]   = proj_t'(prod_x_reg[i]) + proj_t'(prod_y_reg[i]);
        end
    end

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            min_next[t] = proj_reg[VTX_PER_TRI*t];
            max_next[t] = proj_reg[VTX_PER_TRI*t];
            for (int i = 1; i < VTX_PER_TRI; i++)
            begin
                if (proj_reg[VTX_PER_TRI*t + i] < min_next[t])
                begin
                    min_next[t] = proj_reg[VTX_PER_TRI*t + i];
                end
                if (proj_reg[VTX_PER_TRI*t + i] > max_next[t])
                begin
                    max_next[t] = proj_reg[VTX_PER_TRI*t + i];
                end
            end
        end
        sep_next = (max_reg[0] < min_reg[1]) || (max_reg[1] < min_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en.nrm)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
        if (en.prod)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (en.proj)
        begin
            proj_reg <= proj_next;
        end
        if (en.ext)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
        if (en.gap)
        begin
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

// ===== rtl/tri_sat_merge.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap merge stage
// Combines the lane results into the registered overlap flag.
// ----------------------------------------------------------------------------
module tri_sat_merge
    import tri_sat_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [NUM_LANES-1:0] sep,
    output logic                 overlap
);

    logic overlap_reg;
    logic overlap_next;

    // The triangles overlap unless some axis shows a strict gap.
    assign overlap_next = ~|sep;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign overlap = overlap_reg;

endmodule

// ===== rtl/triangle_overlap_sat_test.sv =====
// ----------------------------------------------------------------------------
// Triangle overlap separating axis test
// A request passes the input register, the lane stages and the merge register.
// Throughput: one request per cycle unless stalled; six axis lanes run in
// parallel, each a five stage pipeline, so every stage takes a new
// request each cycle. Stalled stages hold; empty ones ahead still fill.
// Reset clears all stage valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module triangle_overlap_sat_test
    import tri_sat_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  coord_t first_v0_x,
    input  coord_t first_v0_y,
    input  coord_t first_v1_x,
    input  coord_t first_v1_y,
    input  coord_t first_v2_x,
    input  coord_t first_v2_y,
    input  coord_t second_v0_x,
    input  coord_t second_v0_y,
    input  coord_t second_v1_x,
    input  coord_t second_v1_y,
    input  coord_t second_v2_x,
    input  coord_t second_v2_y,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output logic   overlap
);

`include "triangle_overlap_sat_test_assert.svh"

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   stage_free;
    coord_t                req_x [NUM_VTX];
    coord_t                req_y [NUM_VTX];
    coord_t                s1_x_reg [NUM_VTX];
    coord_t                s1_y_reg [NUM_VTX];
    coord_t                s2_x_reg [NUM_VTX];
    coord_t                s2_y_reg [NUM_VTX];
    lane_en_t              lane_en;
    logic [NUM_LANES-1:0]  lane_sep;

    always_comb
    begin
        req_x[0] = first_v0_x;
        req_y[0] = first_v0_y;
        req_x[1] = first_v1_x;
        req_y[1] = first_v1_y;
        req_x[2] = first_v2_x;
        req_y[2] = first_v2_y;
        req_x[3] = second_v0_x;
        req_y[3] = second_v0_y;
        req_x[4] = second_v1_x;
        req_y[4] = second_v1_y;
        req_x[5] = second_v2_x;
        req_y[5] = second_v2_y;
    end

    // A stage can load when it is empty or its content moves on.
    always_comb
    begin
        stage_free[NUM_STAGES] = rsp_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stage_free[k] = !vld_reg[k] || stage_free[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = stage_free[0] ? req_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = stage_free[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_free[0])
        begin
            s1_x_reg <= req_x;
            s1_y_reg <= req_y;
        end
        if (stage_free[1])
        begin
            s2_x_reg <= s1_x_reg;
            s2_y_reg <= s1_y_reg;
        end
    end

    always_comb
    begin
        lane_en.nrm  = stage_free[1];
        lane_en.prod = stage_free[2];
        lane_en.proj = stage_free[3];
        lane_en.ext  = stage_free[4];
        lane_en.gap  = stage_free[5];
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        localparam int TRI = l / VTX_PER_TRI;
        localparam int EDG = l % VTX_PER_TRI;
        localparam int P   = VTX_PER_TRI * TRI + EDG;
        localparam int Q   = VTX_PER_TRI * TRI + (EDG + 1) % VTX_PER_TRI;

        tri_sat_lane u_lane
        (
            .clk (clk),
            .en  (lane_en),
            .p_x (s1_x_reg[P]),
            .p_y (s1_y_reg[P]),
            .q_x (s1_x_reg[Q]),
            .q_y (s1_y_reg[Q]),
            .vx  (s2_x_reg),
            .vy  (s2_y_reg),
            .sep (lane_sep[l])
        );
    end

    tri_sat_merge u_merge
    (
        .clk     (clk),
        .load    (stage_free[NUM_STAGES-1]),
        .sep     (lane_sep),
        .overlap (overlap)
    );

    assign req_ready = stage_free[0];
    assign rsp_valid = vld_reg[NUM_STAGES-1];

    `TRI_SAT_ASSERT_IMP(a_ready_when_drained, !rsp_valid, req_ready)
    `TRI_SAT_ASSERT_NXT(a_accept_enters, req_valid && req_ready, vld_reg[0])
    `TRI_SAT_ASSERT_IMP(a_full_blocks, (&vld_reg) && !rsp_ready, !req_ready)
    `TRI_SAT_ASSERT_NXT(a_last_stage_moves, vld_reg[NUM_STAGES-2] && !rsp_valid, rsp_valid)

endmodule

// ===== verif/triangle_overlap_sat_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle overlap separating axis test bench
// Streams pairs of triangles into the overlap test under changing request
// and response pressure. Each accepted request is predicted exactly with
// 64-bit integer projections, and every response flag is compared in order.
// ----------------------------------------------------------------------------
module triangle_overlap_sat_test_tb
    import tri_sat_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RSP_LATENCY  = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 300;
    localparam int COORD_MAX    = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int COORD_MIN    = -(2 ** (COORD_WIDTH - 1));

    typedef struct packed {
        coord_t [NUM_VTX-1:0] x;
        coord_t [NUM_VTX-1:0] y;
    } tri_pair_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    logic      overlap;
    tri_pair_t offered = '0;

    coord_t first_v0_x;
    coord_t first_v0_y;
    coord_t first_v1_x;
    coord_t first_v1_y;
    coord_t first_v2_x;
    coord_t first_v2_y;
    coord_t second_v0_x;
    coord_t second_v0_y;
    coord_t second_v1_x;
    coord_t second_v1_y;
    coord_t second_v2_x;
    coord_t second_v2_y;

    logic overlap_expected_q[$];
    logic expected_flag;
    int   fail_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_ticket = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    assign first_v0_x  = offered.x[0];
    assign first_v0_y  = offered.y[0];
    assign first_v1_x  = offered.x[1];
    assign first_v1_y  = offered.y[1];
    assign first_v2_x  = offered.x[2];
    assign first_v2_y  = offered.y[2];
    assign second_v0_x = offered.x[3];
    assign second_v0_y = offered.y[3];
    assign second_v1_x = offered.x[4];
    assign second_v1_y = offered.y[4];
    assign second_v2_x = offered.x[5];
    assign second_v2_y = offered.y[5];

    triangle_overlap_sat_test DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .first_v0_x  (first_v0_x),
        .first_v0_y  (first_v0_y),
        .first_v1_x  (first_v1_x),
        .first_v1_y  (first_v1_y),
        .first_v2_x  (first_v2_x),
        .first_v2_y  (first_v2_y),
        .second_v0_x (second_v0_x),
        .second_v0_y (second_v0_y),
        .second_v1_x (second_v1_x),
        .second_v1_y (second_v1_y),
        .second_v2_x (second_v2_x),
        .second_v2_y (second_v2_y),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .overlap     (overlap)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // An edge normal is the edge vector rotated a quarter turn. The pair is
    // apart when some normal shows a strict gap between the two projections.
    function automatic logic triangles_overlap(input tri_pair_t pair);
        longint vx[NUM_VTX];
        longint vy[NUM_VTX];
        longint nx, ny, proj, lo_a, hi_a, lo_b, hi_b;
        int     nxt;
        logic   apart;
        apart = 1'b0;
        lo_a = 0;
        hi_a = 0;
        lo_b = 0;
        hi_b = 0;
        for (int i = 0; i < NUM_VTX; i++)
        begin
            vx[i] = longint'(coord_t'(pair.x[i]));
            vy[i] = longint'(coord_t'(pair.y[i]));
        end
        for (int e = 0; e < NUM_VTX; e++)
        begin
            nxt = (e % VTX_PER_TRI == VTX_PER_TRI - 1) ? e - (VTX_PER_TRI - 1) : e + 1;
            nx = vy[nxt] - vy[e];
            ny = vx[e] - vx[nxt];
            for (int i = 0; i < NUM_VTX; i++)
            begin
                proj = vx[i] * nx + vy[i] * ny;
                if (i == 0)
                begin
                    lo_a = proj;
                    hi_a = proj;
                end
                else if (i == VTX_PER_TRI)
                begin
                    lo_b = proj;
                    hi_b = proj;
                end
                else if (i < VTX_PER_TRI)
                begin
                    if (proj < lo_a) lo_a = proj;
                    if (proj > hi_a) hi_a = proj;
                end
                else
                begin
                    if (proj < lo_b) lo_b = proj;
                    if (proj > hi_b) hi_b = proj;
                end
            end
            if (hi_a < lo_b || hi_b < lo_a) apart = 1'b1;
        end
        return !apart;
    endfunction

    function automatic tri_pair_t pair_of(input int ax, input int ay, input int bx,
                                          input int by, input int cx, input int cy,
                                          input int dx, input int dy, input int ex,
                                          input int ey, input int fx, input int fy);
        tri_pair_t pair;
        pair.x[0] = coord_t'(ax);
        pair.y[0] = coord_t'(ay);
        pair.x[1] = coord_t'(bx);
        pair.y[1] = coord_t'(by);
        pair.x[2] = coord_t'(cx);
        pair.y[2] = coord_t'(cy);
        pair.x[3] = coord_t'(dx);
        pair.y[3] = coord_t'(dy);
        pair.x[4] = coord_t'(ex);
        pair.y[4] = coord_t'(ey);
        pair.x[5] = coord_t'(fx);
        pair.y[5] = coord_t'(fy);
        return pair;
    endfunction

    function automatic coord_t near_coord(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return coord_t'(v);
    endfunction

    // Mostly clustered pairs so that both outcomes and near misses are common.
    function automatic tri_pair_t random_pair();
        tri_pair_t pair;
        int        kind, spread, cx, cy, ox, oy;
        kind = $urandom_range(0, 9);
        spread = 2 << (3 * $urandom_range(0, 4));
        cx = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
        cy = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
        ox = cx + int'($urandom_range(0, 4 * spread)) - 2 * spread;
        oy = cy + int'($urandom_range(0, 4 * spread)) - 2 * spread;
        if (kind < 2)
        begin
            pair = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        end
        else
        begin
            for (int i = 0; i < NUM_VTX; i++)
            begin
                pair.x[i] = near_coord(i < VTX_PER_TRI ? cx : ox, spread);
                pair.y[i] = near_coord(i < VTX_PER_TRI ? cy : oy, spread);
            end
            if (kind == 8)
            begin
                pair.x[VTX_PER_TRI] = pair.x[1];
                pair.y[VTX_PER_TRI] = pair.y[1];
            end
            else if (kind == 9)
            begin
                pair.x[2] = pair.x[1];
                pair.y[2] = pair.y[1];
            end
        end
        return pair;
    endfunction

    always @(posedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (overlap_expected_q.size() == 0)
                begin
                    $error("overlap response with no request outstanding, actual %0b", overlap);
                    fail_count++;
                end
                else
                begin
                    expected_flag = overlap_expected_q.pop_front();
                    if (overlap !== expected_flag)
                    begin
                        $error("field overlap: expected %0b, actual %0b", expected_flag, overlap);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                overlap_expected_q = {overlap_expected_q, triangles_overlap(offered)};
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_pair(input tri_pair_t pair);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        offered   <= pair;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        do @(posedge clk); while (overlap_expected_q.size() != 0);
    endtask

    task automatic test_directed();
        send_pair(pair_of(0, 0, 160, 0, 0, 160, 0, 0, 160, 0, 0, 160));
        send_pair(pair_of(0, 0, 16, 0, 0, 16, 1000, 1000, 1016, 1000, 1000, 1016));
        send_pair(pair_of(0, 0, 16, 0, 0, 16, 16, 0, 32, 0, 32, 16));
        send_pair(pair_of(0, 0, 16, 0, 0, 16, 16, 0, 0, 16, 16, 16));
        send_pair(pair_of(0, 0, 16, 0, 0, 16, 17, 0, 1, 16, 17, 16));
        send_pair(pair_of(-100, -100, 100, -100, 0, 100, -1, -1, 1, -1, 0, 1));
        send_pair(pair_of(0, 0, 0, 16, 16, 0, 40, 40, 40, 56, 56, 40));
        send_pair(pair_of(0, 0, 0, 16, 16, 0, 8, 8, 8, 24, 24, 8));
        send_pair(pair_of(5, 5, 5, 5, 5, 5, 900, -900, 900, -900, 900, -900));
        send_pair(pair_of(-50, -50, 50, -50, 0, 50, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(0, 0, 32, 32, 0, 0, 100, 0, 120, 0, 100, 20));
        send_pair(pair_of(0, 0, 32, 32, 0, 0, 16, 0, 32, 0, 16, 16));
        send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX,
                          COORD_MAX, COORD_MAX - 1));
        send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_pair(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
        send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MIN + 1, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX - 1));
        send_pair(pair_of(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_pair(pair_of(21845, 21845, -21846, 21845, 21845, -21846,
                          -21846, -21846, 21845, -21846, -21846, 21845));
        send_pair(pair_of(-21846, -21846, -21846, 21845, 21845, -21846,
                          21845, 21845, 21845, 21845, 21845, 21845));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct <= stall;
        repeat (count) send_pair(random_pair());
    endtask

    // The response side holds off long enough for the pipeline to fill and
    // stall new requests, then the request side pauses until all are answered.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct   <= 0;
        hold_ticket <= hold_ticket + 1;
        repeat (40) send_pair(random_pair());
        wait_all_answered();
        repeat (20) send_pair(random_pair());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(0, 0, RANDOM_ITEMS);
        test_random_traffic(51, 0, RANDOM_ITEMS);
        test_random_traffic(0, 51, RANDOM_ITEMS);
        test_random_traffic(9, 9, RANDOM_ITEMS);
        test_backpressure();
        wait_all_answered();
        repeat (RSP_LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tri_sat_pkg.sv
rtl/tri_sat_lane.sv
rtl/tri_sat_merge.sv
rtl/triangle_overlap_sat_test.sv
verif/triangle_overlap_sat_test_tb.sv
